FILE: design/ebs_pkg.sv
// ebs_pkg: field widths, register map and helpers for the embedding bag sum unit.
// No dependencies; imported by the top level.
`default_nettype none

package ebs_pkg;

    localparam int ELEMENT_BITS  = 32;
    localparam int SUM_BITS      = 48;

    localparam int ROW_NUM_W     = 12;
    localparam int COL_NUM_W     = 6;
    localparam int VALUE_W       = 32;
    localparam int BAG_W         = 16;

    localparam int ROW_WIDTH_W   = 7;
    localparam int BAG_SIZE_W    = 10;
    localparam int BAG_COUNT_W   = 16;
    localparam int TABLE_ROWS_W  = 13;

    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;

    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 72;

    localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RST  = 7'd64;
    localparam logic [BAG_SIZE_W-1:0]   BAG_SIZE_RST   = 10'd1;
    localparam logic [BAG_COUNT_W-1:0]  BAG_COUNT_RST  = 16'd1;
    localparam logic [TABLE_ROWS_W-1:0] TABLE_ROWS_RST = 13'd4096;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH  = 2'd0,
        REG_BAG_SIZE   = 2'd1,
        REG_BAG_COUNT  = 2'd2,
        REG_TABLE_ROWS = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    // Add one element into a running sum, clamping to the signed sum range.
    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0]     acc,
        input logic [ELEMENT_BITS-1:0] elem
    );
        logic [SUM_BITS:0] a;
        logic [SUM_BITS:0] e;
        logic [SUM_BITS:0] s;
        a = {acc[SUM_BITS-1], acc};
        e = {{(SUM_BITS+1-ELEMENT_BITS){elem[ELEMENT_BITS-1]}}, elem};
        s = a + e;
        if (s[SUM_BITS] != s[SUM_BITS-1]) begin
            sat_add = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                  : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            sat_add = s[SUM_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/embedding_bag_sum_unit.sv
// embedding_bag_sum_unit: embedding table in RAM, per-column bag accumulators, APB config.
// Depends on ebs_pkg and ebs_ram.
//
//  channel   dir  handshake        tdata / tuser
//  s_        in   s_tvalid/ready   row, column, value / action
//  m_        out  m_tvalid/ready   bag, column, sum / last_of_batch, bad_row; tlast = last_of_bag
//  apb       in   psel/penable     4 registers at 4*i
//
//  A lookup beat does the one-element-per-cycle table read and accumulator
//  read-modify-write; a bad-row lookup skips both. Bag end adds result output,
//  one column per beat, held by m_tready stalls; s_tready is low while busy.
//  Reset is synchronous; no clearing pass, the table is undefined until written and
//  accumulators read as zero through per-column valid bits.
`default_nettype none

module embedding_bag_sum_unit
    import ebs_pkg::*;
#(
    parameter int MAX_ROWS    = 4096,
    parameter int MAX_COLUMNS = 64
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [S_TDATA_W-1:0]   s_tdata,   // row_number, column_number, element_value
    input  wire  [0:0]             s_tuser,   // action

    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // bag_index, column_index, column_sum
    output logic                   m_tlast,
    output logic [1:0]             m_tuser,   // last_of_batch, bad_row_seen

    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [CFG_ADDR_W-1:0]  paddr,
    input  wire  [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int COL_BITS  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int TBL_DEPTH = MAX_ROWS << COL_BITS;
    localparam int TBL_AW    = ROW_BITS + COL_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t                     state_reg, state_next;
    logic [ROW_BITS-1:0]        row_reg, row_next;
    logic [COL_NUM_W-1:0]       col_reg, col_next;
    logic                       issue_reg, issue_next;
    logic                       s1_vld_reg, s1_vld_next;
    logic [COL_NUM_W-1:0]       s1_col_reg, s1_col_next;
    logic                       accv_reg, accv_next;
    logic [ROW_WIDTH_W-1:0]     w_reg, w_next;
    logic                       bag_done_reg, bag_done_next;
    logic [BAG_SIZE_W-1:0]      lookups_reg, lookups_next;
    logic [BAG_W-1:0]           cur_bag_reg, cur_bag_next;
    logic                       err_reg, err_next;
    logic [MAX_COLUMNS-1:0]     acc_valid_reg, acc_valid_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [BAG_W-1:0]           m_bag_reg, m_bag_next;
    logic [COL_NUM_W-1:0]       m_col_reg, m_col_next;
    logic [SUM_BITS-1:0]        m_sum_reg, m_sum_next;
    logic                       m_last_reg, m_last_next;
    logic                       m_batch_reg, m_batch_next;
    logic                       m_err_reg, m_err_next;

    logic [ROW_WIDTH_W-1:0]     row_width_reg;
    logic [BAG_SIZE_W-1:0]      bag_size_reg;
    logic [BAG_COUNT_W-1:0]     bag_count_reg;
    logic [TABLE_ROWS_W-1:0]    table_rows_reg;

    logic [ROW_NUM_W-1:0]       s_row;
    logic [COL_NUM_W-1:0]       s_col;
    logic [VALUE_W-1:0]         s_val;
    action_t                    s_action;
    logic                       accept;
    logic                       row_good;
    logic                       col_in_tbl;
    logic                       row_in_tbl;

    logic [ROW_WIDTH_W-1:0]     w_eff;
    logic [ROW_WIDTH_W-1:0]     max_cols;
    logic [BAG_SIZE_W-1:0]      bs_eff;
    logic [BAG_COUNT_W-1:0]     bc_eff;
    logic [BAG_SIZE_W-1:0]      lookups_inc;
    logic                       bag_end;
    logic                       last_batch;

    logic [COL_NUM_W-1:0]       col_inc;
    logic                       col_last;
    logic                       s1_last;
    logic                       out_free;
    logic                       emit_go;

    logic                       tbl_we, tbl_re;
    logic [TBL_AW-1:0]          tbl_waddr, tbl_raddr;
    logic [ELEMENT_BITS-1:0]    tbl_rdata;
    logic                       acc_we, acc_re;
    logic [COL_BITS-1:0]        acc_waddr, acc_raddr;
    logic [SUM_BITS-1:0]        acc_wdata, acc_rdata;

    logic                       cfg_we;
    cfg_reg_t                   cfg_sel;

    // Input beat decode
    assign s_row      = s_tdata[11:0];
    assign s_col      = s_tdata[17:12];
    assign s_val      = s_tdata[49:18];
    assign s_action   = action_t'(s_tuser[0]);
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign row_in_tbl = 32'(s_row) < 32'(MAX_ROWS);
    assign col_in_tbl = 32'(s_col) < 32'(MAX_COLUMNS);
    assign row_good   = row_in_tbl && ({1'b0, s_row} < table_rows_reg);

    // Effective register values
    assign max_cols    = ROW_WIDTH_W'(MAX_COLUMNS);
    assign w_eff       = (row_width_reg == '0) ? ROW_WIDTH_W'(1) :
                         ((row_width_reg > max_cols) ? max_cols : row_width_reg);
    assign bs_eff      = (bag_size_reg == '0) ? BAG_SIZE_W'(1) : bag_size_reg;
    assign bc_eff      = (bag_count_reg == '0) ? BAG_COUNT_W'(1) : bag_count_reg;
    assign lookups_inc = lookups_reg + BAG_SIZE_W'(1);
    assign bag_end     = lookups_inc >= bs_eff;
    assign last_batch  = ({1'b0, cur_bag_reg} + (BAG_W+1)'(1)) >= {1'b0, bc_eff};

    assign col_inc  = col_reg + COL_NUM_W'(1);
    assign col_last = ({1'b0, col_reg} + ROW_WIDTH_W'(1)) == w_reg;
    assign s1_last  = ({1'b0, s1_col_reg} + ROW_WIDTH_W'(1)) == w_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = (state_reg == ST_EMIT_LD) && out_free;

    // Table memory
    assign tbl_we    = accept && (s_action == ACT_WRITE) && row_in_tbl && col_in_tbl;
    assign tbl_waddr = {ROW_BITS'(s_row), COL_BITS'(s_col)};
    assign tbl_re    = (state_reg == ST_ACC) && issue_reg;
    assign tbl_raddr = {row_reg, col_reg[COL_BITS-1:0]};

    ebs_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (s_val[ELEMENT_BITS-1:0]),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Accumulator memory: read column c while column c-1 is written back
    assign acc_we    = (state_reg == ST_ACC) && s1_vld_reg;
    assign acc_waddr = s1_col_reg[COL_BITS-1:0];
    assign acc_wdata = sat_add(accv_reg ? acc_rdata : '0, tbl_rdata);
    assign acc_re    = tbl_re || (state_reg == ST_EMIT_RD) || (emit_go && !col_last);
    assign acc_raddr = (state_reg == ST_EMIT_LD) ? col_inc[COL_BITS-1:0]
                                                 : col_reg[COL_BITS-1:0];

    ebs_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        issue_next     = issue_reg;
        s1_vld_next    = s1_vld_reg;
        s1_col_next    = s1_col_reg;
        accv_next      = accv_reg;
        w_next         = w_reg;
        bag_done_next  = bag_done_reg;
        lookups_next   = lookups_reg;
        cur_bag_next   = cur_bag_reg;
        err_next       = err_reg;
        acc_valid_next = acc_valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_bag_next     = m_bag_reg;
        m_col_next     = m_col_reg;
        m_sum_next     = m_sum_reg;
        m_last_next    = m_last_reg;
        m_batch_next   = m_batch_reg;
        m_err_next     = m_err_reg;

        if (acc_re) begin
            accv_next = acc_valid_reg[acc_raddr];
        end
        if (acc_we) begin
            acc_valid_next[acc_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_action == ACT_LOOKUP)) begin
                    w_next        = w_eff;
                    bag_done_next = bag_end;
                    lookups_next  = bag_end ? '0 : lookups_inc;
                    col_next      = '0;
                    if (!row_good) begin
                        err_next = 1'b1;
                    end
                    if (row_good) begin
                        row_next    = ROW_BITS'(s_row);
                        issue_next  = 1'b1;
                        s1_vld_next = 1'b0;
                        state_next  = ST_ACC;
                    end else if (bag_end) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_ACC: begin
                s1_vld_next = issue_reg;
                s1_col_next = col_reg;
                if (issue_reg) begin
                    if (col_last) begin
                        issue_next = 1'b0;
                    end else begin
                        col_next = col_inc;
                    end
                end
                if (s1_vld_reg && s1_last) begin
                    s1_vld_next = 1'b0;
                    col_next    = '0;
                    state_next  = bag_done_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_bag_next    = cur_bag_reg;
                    m_col_next    = col_reg;
                    m_sum_next    = accv_reg ? acc_rdata : '0;
                    m_last_next   = col_last;
                    m_batch_next  = last_batch;
                    m_err_next    = err_reg;
                    if (col_last) begin
                        acc_valid_next = '0;
                        err_next       = 1'b0;
                        cur_bag_next   = last_batch ? '0 : (cur_bag_reg + BAG_W'(1));
                        col_next       = '0;
                        state_next     = ST_IDLE;
                    end else begin
                        col_next = col_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            s1_vld_reg    <= 1'b0;
            bag_done_reg  <= 1'b0;
            lookups_reg   <= '0;
            cur_bag_reg   <= '0;
            err_reg       <= 1'b0;
            acc_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            col_reg       <= '0;
            w_reg         <= ROW_WIDTH_RST;
        end else begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            s1_vld_reg    <= s1_vld_next;
            bag_done_reg  <= bag_done_next;
            lookups_reg   <= lookups_next;
            cur_bag_reg   <= cur_bag_next;
            err_reg       <= err_next;
            acc_valid_reg <= acc_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            col_reg       <= col_next;
            w_reg         <= w_next;
            row_reg       <= row_next;
            s1_col_reg    <= s1_col_next;
            accv_reg      <= accv_next;
            m_bag_reg     <= m_bag_next;
            m_col_reg     <= m_col_next;
            m_sum_reg     <= m_sum_next;
            m_last_reg    <= m_last_next;
            m_batch_reg   <= m_batch_next;
            m_err_reg     <= m_err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_sum_reg, m_col_reg, m_bag_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_err_reg, m_batch_reg};

    // APB registers
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg  <= ROW_WIDTH_RST;
            bag_size_reg   <= BAG_SIZE_RST;
            bag_count_reg  <= BAG_COUNT_RST;
            table_rows_reg <= TABLE_ROWS_RST;
        end else if (cfg_we) begin
            unique case (cfg_sel)
                REG_ROW_WIDTH:  row_width_reg  <= pwdata[ROW_WIDTH_W-1:0];
                REG_BAG_SIZE:   bag_size_reg   <= pwdata[BAG_SIZE_W-1:0];
                REG_BAG_COUNT:  bag_count_reg  <= pwdata[BAG_COUNT_W-1:0];
                REG_TABLE_ROWS: table_rows_reg <= pwdata[TABLE_ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ROW_WIDTH:  prdata = CFG_DATA_W'(row_width_reg);
            REG_BAG_SIZE:   prdata = CFG_DATA_W'(bag_size_reg);
            REG_BAG_COUNT:  prdata = CFG_DATA_W'(bag_count_reg);
            REG_TABLE_ROWS: prdata = CFG_DATA_W'(table_rows_reg);
            default:        prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_acc_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_we && acc_re |-> acc_waddr != acc_raddr)
        else $error("accumulator read and write hit the same column");

    a_tbl_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> !tbl_re)
        else $error("table write during a row read");

    a_bag_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && col_last |=> acc_valid_reg == '0 && !err_reg)
        else $error("accumulators not cleared after bag output");
`endif

endmodule

`default_nettype wire

FILE: design/ebs_ram.sv
// ebs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ebs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                                    aclk,
    input  wire                                    we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                       wdata,
    input  wire                                    re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
